// ===== hw/rtl/assert_macros.svh =====
// Assertion helpers shared by the RTL that checks itself.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define FFA_ASSERT_IMPL(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("ffa: same-cycle check failed");

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define FFA_ASSERT_NEXT(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("ffa: next-cycle check failed");

`endif

// ===== hw/rtl/ffa_pkg.sv =====
package ffa_pkg;

   // Link granule index wide enough for any split point of the largest heap.
   localparam int LINK_W    = 18;
   localparam int SIZE_W    = 32;
   localparam int OFF_W     = 17;
   localparam int HOPS_W    = 13;
   localparam int HDR_BYTES = 24;
   localparam int HOPS_SAT  = 4095;
   localparam int NUM_FOPS  = 8;

   localparam logic OP_ALLOC = 1'b0;
   localparam logic OP_FREE  = 1'b1;

   typedef struct packed {
      logic              v;
      logic [LINK_W-1:0] g;
   } link_type;

   typedef struct packed {
      logic [SIZE_W-1:0] size;
      logic              used;
      link_type          next;
      link_type          prev;
   } hdr_type;

   typedef enum logic [1:0] {
      FLD_SIZE,
      FLD_USED,
      FLD_NEXT,
      FLD_PREV
   } fld_type;

   // One pending field update of a header entry.
   typedef struct packed {
      logic              en;
      logic [LINK_W-1:0] addr;
      fld_type           fld;
      logic [SIZE_W-1:0] val;
   } fop_type;

   typedef struct packed {
      logic              rd_en;
      logic [LINK_W-1:0] rd_addr;
      logic              wr_en;
      logic [LINK_W-1:0] wr_addr;
      hdr_type           wr_data;
   } mem_req_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_A_RD,
      ST_A_CHK,
      ST_F_RD,
      ST_F_CHK,
      ST_F_RDP,
      ST_F_RDB,
      ST_F_RDN,
      ST_F_DEC,
      ST_OP_RD,
      ST_OP_WR,
      ST_DONE
   } state_type;

   function automatic link_type mk_link(logic [LINK_W-1:0] g);
      link_type l;
      l.v = 1'b1;
      l.g = g;
      return l;
   endfunction

   function automatic logic [SIZE_W-1:0] link_val(link_type l);
      return SIZE_W'(l);
   endfunction

   function automatic fop_type mk_fop(logic en, logic [LINK_W-1:0] addr, fld_type fld,
                                      logic [SIZE_W-1:0] val);
      fop_type f;
      f.en   = en;
      f.addr = addr;
      f.fld  = fld;
      f.val  = val;
      return f;
   endfunction

   // Merge one field into a header that was just read.
   function automatic hdr_type set_field(hdr_type h, fld_type f, logic [SIZE_W-1:0] v);
      hdr_type r;
      r = h;
      unique case (f)
         FLD_SIZE: r.size = v;
         FLD_USED: r.used = v[0];
         FLD_NEXT: r.next = link_type'(v[LINK_W:0]);
         FLD_PREV: r.prev = link_type'(v[LINK_W:0]);
      endcase
      return r;
   endfunction

endpackage

// ===== hw/rtl/ffa_if.sv =====
interface ffa_req_if;
   logic               valid;
   logic               ready;
   logic               op;
   logic signed [16:0] payload_bytes;
   logic [16:0]        free_offset;
   modport source (output valid, op, payload_bytes, free_offset, input ready);
   modport sink (input valid, op, payload_bytes, free_offset, output ready);
endinterface

interface ffa_rsp_if;
   logic               valid;
   logic               ready;
   logic               ok;
   logic signed [16:0] payload_offset;
   logic signed [12:0] hops;
   modport source (output valid, ok, payload_offset, hops, input ready);
   modport sink (input valid, ok, payload_offset, hops, output ready);
endinterface

interface ffa_csr_if;
   logic        valid;
   logic        ready;
   logic [16:0] region_bytes;
   modport source (output valid, region_bytes, input ready);
   modport sink (input valid, region_bytes, output ready);
endinterface

// ===== hw/rtl/ffa_hdr_mem.sv =====
module ffa_hdr_mem import ffa_pkg::*; #(
   parameter int DEPTH = 8192
) (
   input  logic        clock,
   input  mem_req_type mem_req,
   output hdr_type     rdata
);

   localparam int AW = $clog2(DEPTH);

   hdr_type mem_ff [DEPTH];
   hdr_type rdata_ff;

   // One write port, one registered read port
   always_ff @(posedge clock) begin
      if (mem_req.wr_en) begin
         mem_ff[mem_req.wr_addr[AW-1:0]] <= mem_req.wr_data;
      end
      if (mem_req.rd_en) begin
         rdata_ff <= mem_ff[mem_req.rd_addr[AW-1:0]];
      end
   end

   assign rdata = rdata_ff;

endmodule

// ===== hw/rtl/ffa_ctrl.sv =====
module ffa_ctrl import ffa_pkg::*; #(
   parameter int HEAP_BYTES = 65536,
   parameter int PAGE_BYTES = 4096
) (
   input  logic        clock,
   input  logic        reset,
   ffa_req_if.sink     req,
   ffa_rsp_if.source   rsp,
   ffa_csr_if.sink     csr,
   output mem_req_type mem_req,
   input  hdr_type     mem_rdata
);

   localparam int NGRAN = HEAP_BYTES / 8;
   localparam int GW    = $clog2(NGRAN);
   localparam int CNT_W = GW + 2;
   localparam int LEN_W = (($clog2(HEAP_BYTES) > OFF_W) ? $clog2(HEAP_BYTES) : OFF_W) + 2;
   localparam logic [CNT_W-1:0]  NGRAN_C = CNT_W'(NGRAN);
   localparam logic [LINK_W-1:0] NGRAN_L = LINK_W'(NGRAN);
   localparam logic [LEN_W-1:0]  HEAP_L  = LEN_W'(HEAP_BYTES);
   localparam logic [LEN_W-1:0]  PAGE_L  = LEN_W'(PAGE_BYTES);

   state_type state_ff, state_in;

   logic [OFF_W-1:0]  region_ff;
   logic [LEN_W-1:0]  acc_ff;
   logic [LEN_W-1:0]  heap_len_ff;
   logic [GW-1:0]     clr_addr_ff;
   link_type          head_ff;
   link_type          cur_ff;
   logic [CNT_W-1:0]  hops_ff;
   logic [17:0]       need_ff;
   logic [OFF_W-1:0]  off_ff;
   link_type          prv_ff, nxt_ff, nn_ff;
   hdr_type           pp_ff, hb_ff;
   fop_type           fop_ff [NUM_FOPS];
   logic [3:0]        fidx_ff;
   logic              oob_ff;
   logic              res_ok_ff;
   logic [OFF_W-1:0]  res_off_ff;
   logic [HOPS_W-1:0] res_hops_ff;
   logic              rsp_valid_ff;
   logic              rsp_ok_ff;
   logic [OFF_W-1:0]  rsp_off_ff;
   logic [HOPS_W-1:0] rsp_hops_ff;

   logic              req_fire, csr_fire, rsp_free;
   hdr_type           rdat;
   logic              round_done;
   logic [LEN_W-1:0]  len_w;
   logic [16:0]       pay_w;
   logic [17:0]       need_w;
   logic              req_bad;
   logic [32:0]       left_w;
   logic              a_fit, a_split, a_walk_end;
   logic              f_walk_fail, f_stop;
   logic [OFF_W-1:0]  pbyte;
   logic [LINK_W-1:0] pb;
   logic [LINK_W-1:0] nb;
   logic              lc, rc;
   fop_type           cur_op;
   logic              op_skip;
   logic [HOPS_W-1:0] hops_sat;
   fop_type           a_ops [NUM_FOPS];
   fop_type           f_ops [NUM_FOPS];
   link_type          a_head, f_head;

   assign req_fire = req.valid && req.ready;
   assign csr_fire = csr.valid && csr.ready;
   assign rsp_free = !rsp_valid_ff || rsp.ready;
   assign rdat     = oob_ff ? hdr_type'('0) : mem_rdata;

   // Region rounding, one page a cycle during the clearing sweep
   assign round_done = acc_ff >= LEN_W'(region_ff);
   assign len_w      = (acc_ff > HEAP_L) ? HEAP_L : acc_ff;

   // Request decode
   assign pay_w  = (17'(req.payload_bytes[15:0]) + 17'd7) & ~17'd7;
   assign need_w = 18'(pay_w) + 18'(HDR_BYTES);
   always_comb begin
      if (req.op == OP_ALLOC) begin
         req_bad = req.payload_bytes[16];
      end else begin
         req_bad = (req.free_offset < OFF_W'(HDR_BYTES)) ||
                   (LEN_W'(req.free_offset) > heap_len_ff) ||
                   (req.free_offset[2:0] != 3'd0);
      end
   end

   // Fit test on the header just read
   assign left_w     = {1'b0, rdat.size} - 33'(need_ff);
   assign a_split    = !left_w[32] && (left_w >= 33'(HDR_BYTES));
   assign a_fit      = !left_w[32] && (a_split || (left_w[2:0] == 3'd0));
   assign a_walk_end = !cur_ff.v || (hops_ff >= NGRAN_C);
   assign nb         = cur_ff.g + LINK_W'(need_ff[17:3]);

   // Free walk and coalesce tests
   assign f_walk_fail = hops_ff > NGRAN_C;
   assign f_stop      = (LINK_W+3)'(off_ff) < {cur_ff.g, 3'b000};
   assign pbyte       = off_ff - OFF_W'(HDR_BYTES);
   assign pb          = LINK_W'(pbyte[16:3]);
   assign lc = prv_ff.v && !pp_ff.used &&
               (34'({prv_ff.g, 3'b000}) + 34'(pp_ff.size) == 34'(pbyte));
   assign rc = nxt_ff.v && !rdat.used &&
               (34'(pbyte) + 34'(hb_ff.size) == 34'({nxt_ff.g, 3'b000}));

   assign cur_op   = fop_ff[fidx_ff[2:0]];
   assign op_skip  = !cur_op.en || (cur_op.addr >= NGRAN_L);
   assign hops_sat = (hops_ff > CNT_W'(HOPS_SAT)) ? HOPS_W'(HOPS_SAT) : HOPS_W'(hops_ff);

   // Field updates of an allocation, in list order
   always_comb begin
      for (int i = 0; i < NUM_FOPS; i++) begin
         a_ops[i] = '0;
      end
      a_head = head_ff;
      if (a_split) begin
         a_ops[0] = mk_fop(1'b1, nb, FLD_SIZE, left_w[31:0]);
         a_ops[1] = mk_fop(1'b1, nb, FLD_USED, '0);
         a_ops[2] = mk_fop(rdat.prev.v, rdat.prev.g, FLD_NEXT, link_val(mk_link(nb)));
         a_ops[3] = mk_fop(rdat.next.v, rdat.next.g, FLD_PREV, link_val(mk_link(nb)));
         a_ops[4] = mk_fop(1'b1, nb, FLD_NEXT, link_val(rdat.next));
         a_ops[5] = mk_fop(1'b1, nb, FLD_PREV, link_val(rdat.prev));
         a_ops[6] = mk_fop(1'b1, cur_ff.g, FLD_SIZE, SIZE_W'(need_ff));
         a_ops[7] = mk_fop(1'b1, cur_ff.g, FLD_USED, SIZE_W'(1));
         if (!rdat.prev.v) begin
            a_head = mk_link(nb);
         end
      end else begin
         a_ops[0] = mk_fop(rdat.prev.v, rdat.prev.g, FLD_NEXT, link_val(rdat.next));
         a_ops[1] = mk_fop(rdat.next.v, rdat.next.g, FLD_PREV, link_val(rdat.prev));
         a_ops[2] = mk_fop(1'b1, cur_ff.g, FLD_SIZE, rdat.size);
         a_ops[3] = mk_fop(1'b1, cur_ff.g, FLD_USED, SIZE_W'(1));
         if (!rdat.prev.v) begin
            a_head = rdat.next;
         end
      end
   end

   // Field updates of a free, in list order
   always_comb begin
      for (int i = 0; i < NUM_FOPS; i++) begin
         f_ops[i] = '0;
      end
      if (lc && rc) begin
         f_ops[0] = mk_fop(1'b1, prv_ff.g, FLD_SIZE, pp_ff.size + hb_ff.size + rdat.size);
         f_ops[1] = mk_fop(1'b1, prv_ff.g, FLD_NEXT, link_val(rdat.next));
         f_ops[2] = mk_fop(nn_ff.v, nn_ff.g, FLD_PREV, link_val(prv_ff));
      end else if (rc) begin
         f_ops[0] = mk_fop(1'b1, pb, FLD_SIZE, hb_ff.size + rdat.size);
         f_ops[1] = mk_fop(1'b1, pb, FLD_NEXT, link_val(rdat.next));
         f_ops[2] = mk_fop(nn_ff.v, nn_ff.g, FLD_PREV, link_val(mk_link(pb)));
         f_ops[3] = mk_fop(1'b1, pb, FLD_PREV, link_val(prv_ff));
         f_ops[4] = mk_fop(prv_ff.v, prv_ff.g, FLD_NEXT, link_val(mk_link(pb)));
         f_ops[5] = mk_fop(1'b1, pb, FLD_USED, '0);
      end else if (lc) begin
         f_ops[0] = mk_fop(1'b1, prv_ff.g, FLD_SIZE, pp_ff.size + hb_ff.size);
         f_ops[1] = mk_fop(1'b1, prv_ff.g, FLD_NEXT, link_val(nxt_ff));
         f_ops[2] = mk_fop(nxt_ff.v, nxt_ff.g, FLD_PREV, link_val(prv_ff));
      end else begin
         f_ops[0] = mk_fop(prv_ff.v, prv_ff.g, FLD_NEXT, link_val(mk_link(pb)));
         f_ops[1] = mk_fop(nxt_ff.v, nxt_ff.g, FLD_PREV, link_val(mk_link(pb)));
         f_ops[2] = mk_fop(1'b1, pb, FLD_NEXT, link_val(nxt_ff));
         f_ops[3] = mk_fop(1'b1, pb, FLD_PREV, link_val(prv_ff));
         f_ops[4] = mk_fop(1'b1, pb, FLD_USED, '0);
      end
      f_head = head_ff;
      if (((cur_ff.v == head_ff.v) && (!cur_ff.v || (cur_ff.g == head_ff.g))) ||
          !head_ff.v) begin
         f_head = mk_link(pb);
      end
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      if (csr_fire) begin
         state_in = ST_CLEAR;
      end else begin
         unique case (state_ff)
            ST_CLEAR: if ((clr_addr_ff == '0) && round_done) state_in = ST_IDLE;
            ST_IDLE: begin
               if (req_fire) begin
                  if (req_bad)                  state_in = ST_DONE;
                  else if (req.op == OP_ALLOC)  state_in = ST_A_RD;
                  else                          state_in = ST_F_RD;
               end
            end
            ST_A_RD:  state_in = a_walk_end ? ST_DONE : ST_A_CHK;
            ST_A_CHK: state_in = a_fit ? ST_OP_RD : ST_A_RD;
            ST_F_RD: begin
               if (f_walk_fail)   state_in = ST_DONE;
               else if (!cur_ff.v) state_in = ST_F_RDP;
               else               state_in = ST_F_CHK;
            end
            ST_F_CHK: state_in = f_stop ? ST_F_RDP : ST_F_RD;
            ST_F_RDP: state_in = ST_F_RDB;
            ST_F_RDB: state_in = ST_F_RDN;
            ST_F_RDN: state_in = ST_F_DEC;
            ST_F_DEC: state_in = ST_OP_RD;
            ST_OP_RD: begin
               if (fidx_ff[3])    state_in = ST_DONE;
               else if (!op_skip) state_in = ST_OP_WR;
            end
            ST_OP_WR: state_in = ST_OP_RD;
            ST_DONE:  if (rsp_free) state_in = ST_IDLE;
            default:  state_in = ST_CLEAR;
         endcase
      end
   end

   // Memory port and handshake outputs
   always_comb begin
      mem_req = '0;
      unique case (state_ff)
         ST_CLEAR: begin
            mem_req.wr_en   = 1'b1;
            mem_req.wr_addr = LINK_W'(clr_addr_ff);
            if ((clr_addr_ff == '0) && round_done) begin
               mem_req.wr_data.size = SIZE_W'(len_w);
            end
         end
         ST_A_RD, ST_F_RD: begin
            mem_req.rd_en   = 1'b1;
            mem_req.rd_addr = cur_ff.g;
         end
         ST_F_RDP: begin
            mem_req.rd_en   = 1'b1;
            mem_req.rd_addr = prv_ff.g;
         end
         ST_F_RDB: begin
            mem_req.rd_en   = 1'b1;
            mem_req.rd_addr = pb;
         end
         ST_F_RDN: begin
            mem_req.rd_en   = 1'b1;
            mem_req.rd_addr = nxt_ff.g;
         end
         ST_OP_RD: begin
            mem_req.rd_en   = !fidx_ff[3] && !op_skip;
            mem_req.rd_addr = cur_op.addr;
         end
         ST_OP_WR: begin
            mem_req.wr_en   = 1'b1;
            mem_req.wr_addr = cur_op.addr;
            mem_req.wr_data = set_field(rdat, cur_op.fld, cur_op.val);
         end
         default: mem_req = '0;
      endcase
   end

   assign req.ready          = (state_ff == ST_IDLE);
   assign csr.ready          = 1'b1;
   assign rsp.valid          = rsp_valid_ff;
   assign rsp.ok             = rsp_ok_ff;
   assign rsp.payload_offset = rsp_off_ff;
   assign rsp.hops           = rsp_hops_ff;

   // Datapath and control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         region_ff    <= 17'h10000;
         acc_ff       <= '0;
         heap_len_ff  <= '0;
         clr_addr_ff  <= GW'(NGRAN - 1);
         head_ff      <= '0;
         fidx_ff      <= '0;
         oob_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         oob_ff   <= mem_req.rd_addr >= NGRAN_L;
         if (csr_fire) begin
            region_ff   <= csr.region_bytes;
            acc_ff      <= '0;
            clr_addr_ff <= GW'(NGRAN - 1);
         end else begin
            case (state_ff)
               ST_CLEAR: begin
                  if (!round_done) acc_ff <= acc_ff + PAGE_L;
                  if (clr_addr_ff != '0) begin
                     clr_addr_ff <= clr_addr_ff - GW'(1);
                  end else if (round_done) begin
                     heap_len_ff <= len_w;
                     head_ff     <= (len_w != '0) ? mk_link('0) : link_type'('0);
                  end
               end
               ST_IDLE: begin
                  if (req_fire) begin
                     off_ff  <= req.free_offset;
                     need_ff <= need_w;
                     cur_ff  <= head_ff;
                     hops_ff <= '0;
                     nxt_ff  <= '0;
                     fidx_ff <= '0;
                     res_ok_ff   <= 1'b0;
                     res_off_ff  <= '1;
                     res_hops_ff <= '1;
                  end
               end
               ST_A_CHK: begin
                  if (a_fit) begin
                     for (int i = 0; i < NUM_FOPS; i++) fop_ff[i] <= a_ops[i];
                     head_ff     <= a_head;
                     res_ok_ff   <= 1'b1;
                     res_off_ff  <= OFF_W'({cur_ff.g, 3'b000} + (LINK_W+3)'(HDR_BYTES));
                     res_hops_ff <= hops_sat;
                  end else begin
                     cur_ff  <= rdat.next;
                     hops_ff <= hops_ff + CNT_W'(1);
                  end
               end
               ST_F_RD: begin
                  if (!f_walk_fail && !cur_ff.v) begin
                     prv_ff <= (hops_ff == '0) ? link_type'('0) : nxt_ff;
                     nxt_ff <= '0;
                     nn_ff  <= '0;
                  end
               end
               ST_F_CHK: begin
                  nxt_ff <= cur_ff;
                  nn_ff  <= rdat.next;
                  prv_ff <= rdat.prev;
                  if (!f_stop) begin
                     cur_ff  <= rdat.next;
                     hops_ff <= hops_ff + CNT_W'(1);
                  end
               end
               ST_F_RDB: pp_ff <= rdat;
               ST_F_RDN: hb_ff <= rdat;
               ST_F_DEC: begin
                  for (int i = 0; i < NUM_FOPS; i++) fop_ff[i] <= f_ops[i];
                  head_ff     <= f_head;
                  res_ok_ff   <= 1'b1;
                  res_hops_ff <= hops_sat;
               end
               ST_OP_RD: if (!fidx_ff[3] && op_skip) fidx_ff <= fidx_ff + 4'd1;
               ST_OP_WR: fidx_ff <= fidx_ff + 4'd1;
               default: ;
            endcase
         end
         // Result register: hold until the transfer, then take the next one
         if (rsp.valid && rsp.ready) rsp_valid_ff <= 1'b0;
         if ((state_ff == ST_DONE) && rsp_free) begin
            rsp_valid_ff <= 1'b1;
            rsp_ok_ff    <= res_ok_ff;
            rsp_off_ff   <= res_off_ff;
            rsp_hops_ff  <= res_hops_ff;
         end
      end
   end

endmodule

// ===== hw/rtl/first_fit_free_list_allocator_core.sv =====
// Channel | Dir | Transfer moves
// req     | in  | op, payload_bytes, free_offset
// rsp     | out | ok, payload_offset, hops
// csr     | in  | region_bytes (rebuilds the heap)
//
// An allocate reads and checks the header of each free-list link it visits,
// then reads and rewrites a header for each field update; a free walks the
// list, reads the previous, freed and next headers, then does its updates.
// After reset or a csr transfer, a clearing pass writes every header and
// rounds the region up to whole pages, with req.ready low. A waiting result
// holds the next one in ST_DONE, with req.ready low, until it can be registered.
`include "assert_macros.svh"

module first_fit_free_list_allocator_core import ffa_pkg::*; #(
   parameter int HEAP_BYTES = 65536,
   parameter int PAGE_BYTES = 4096
) (
   input logic       clock,
   input logic       reset,
   ffa_req_if.sink   req,
   ffa_rsp_if.source rsp,
   ffa_csr_if.sink   csr
);

   mem_req_type mem_req;
   hdr_type     mem_rdata;

   ffa_ctrl #(
      .HEAP_BYTES (HEAP_BYTES),
      .PAGE_BYTES (PAGE_BYTES)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req       (req),
      .rsp       (rsp),
      .csr       (csr),
      .mem_req   (mem_req),
      .mem_rdata (mem_rdata)
   );

   ffa_hdr_mem #(
      .DEPTH (HEAP_BYTES / 8)
   ) u_mem (
      .clock   (clock),
      .mem_req (mem_req),
      .rdata   (mem_rdata)
   );

   // One request in flight at a time
   `FFA_ASSERT_NEXT(a_one_req, req.valid && req.ready, !req.ready)
   // A region write starts the clearing pass
   `FFA_ASSERT_NEXT(a_cfg_clear, csr.valid && csr.ready, !req.ready)
   // Read and write of the header store never share a cycle
   `FFA_ASSERT_IMPL(a_port_excl, mem_req.wr_en, !mem_req.rd_en)

endmodule
